// ----- rtl/core/srd_pkg.sv -----
package srd_pkg;

    // Largest row width and frame height the decoder handles.
    localparam int unsigned MaxWidth  = 1024;
    localparam int unsigned MaxHeight = 1024;

    localparam int unsigned DimW = 11;
    localparam int unsigned PosW = 10;

    // Configuration register indexes.
    localparam logic [1:0] REG_COMPRESSED_MODE   = 2'd0;
    localparam logic [1:0] REG_TRANSPARENT_INDEX = 2'd1;
    localparam logic [1:0] REG_FRAME_WIDTH       = 2'd2;
    localparam logic [1:0] REG_FRAME_HEIGHT      = 2'd3;

    // Command mask bits.
    localparam logic [7:0] MASK_TRANSPARENT = 8'h01;
    localparam logic [7:0] MASK_REPEAT      = 8'h02;

    typedef struct packed {
        logic            compressed_mode;
        logic [7:0]      transparent_index;
        logic [DimW-1:0] frame_width;
        logic [DimW-1:0] frame_height;
    } cfg_t;

    typedef struct packed {
        logic [7:0]      pixel_value;
        logic [DimW-1:0] run_length;
        logic [PosW-1:0] start_x;
        logic [PosW-1:0] row_index;
        logic            row_done;
        logic            frame_done;
        logic            has_transparency;
        logic            overflow;
    } run_t;

endpackage

// ----- rtl/core/srd_parser.sv -----
module srd_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  srd_pkg::cfg_t        cfg,
    input  logic                 restart,
    input  logic                 step,
    input  logic [7:0]           byte_in,
    output logic                 emit,
    output srd_pkg::run_t        run
);

    typedef enum logic [4:0] {
        PH_HDR_LO  = 5'b00001,
        PH_HDR_HI  = 5'b00010,
        PH_MASK    = 5'b00100,
        PH_REPEAT  = 5'b01000,
        PH_LITERAL = 5'b10000
    } phase_t;

    phase_t                    phase_reg, phase_next;
    logic [15:0]               bytes_left_reg, bytes_left_next;
    logic [7:0]                header_reg, header_next;
    logic [srd_pkg::DimW-1:0]  column_reg, column_next;
    logic [srd_pkg::PosW-1:0]  row_reg, row_next;
    logic [6:0]                pending_reg, pending_next;
    logic                      saw_reg, saw_next;

    logic [srd_pkg::DimW-1:0]  width;
    logic [srd_pkg::DimW-1:0]  height;
    logic [15:0]               bytes_dec;
    logic [15:0]               count;
    logic [6:0]                pend_dec;
    logic                      call;
    logic                      ends;
    logic [7:0]                value;
    logic [7:0]                remapped;
    logic [srd_pkg::DimW-1:0]  len;
    logic [srd_pkg::DimW-1:0]  left;
    logic [srd_pkg::DimW-1:0]  run_len;
    logic                      col_past;
    logic                      clip;
    logic                      saw_set;
    logic                      last_row;

    function automatic logic [srd_pkg::DimW-1:0] clamp_dim(
        input logic [srd_pkg::DimW-1:0] v,
        input logic [srd_pkg::DimW-1:0] max_v
    );
        logic [srd_pkg::DimW-1:0] r;
        r = v;
        if (r == '0)
        begin
            r = srd_pkg::DimW'(1);
        end
        if (r > max_v)
        begin
            r = max_v;
        end
        return r;
    endfunction

    assign width    = clamp_dim(cfg.frame_width, srd_pkg::DimW'(srd_pkg::MaxWidth));
    assign height   = clamp_dim(cfg.frame_height, srd_pkg::DimW'(srd_pkg::MaxHeight));
    assign bytes_dec = (bytes_left_reg != '0) ? bytes_left_reg - 16'd1 : bytes_left_reg;
    assign pend_dec  = (pending_reg != '0) ? pending_reg - 7'd1 : pending_reg;
    assign count     = {byte_in, header_reg};
    assign remapped  = (byte_in == cfg.transparent_index) ? 8'd0 : byte_in;
    assign last_row  = ({1'b0, row_reg} + srd_pkg::DimW'(1)) >= height;

    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        header_next     = header_reg;
        pending_next    = pending_reg;
        saw_set         = saw_reg;
        call            = 1'b0;
        ends            = 1'b0;
        value           = '0;
        len             = '0;

        if (!cfg.compressed_mode)
        begin
            call  = 1'b1;
            value = byte_in;
            len   = srd_pkg::DimW'(1);
            ends  = ({1'b0, column_reg} + (srd_pkg::DimW + 1)'(1)) >= {1'b0, width};
        end
        else
        begin
            unique case (phase_reg)
                PH_HDR_LO:
                begin
                    header_next = byte_in;
                    phase_next  = PH_HDR_HI;
                end
                PH_HDR_HI:
                begin
                    if (count == '0)
                    begin
                        // An empty row is one transparent run across its width.
                        saw_set = 1'b1;
                        call    = 1'b1;
                        value   = cfg.transparent_index;
                        len     = width;
                        ends    = 1'b1;
                    end
                    else
                    begin
                        bytes_left_next = count;
                        phase_next      = PH_MASK;
                    end
                end
                PH_MASK:
                begin
                    bytes_left_next = bytes_dec;
                    if ((byte_in & srd_pkg::MASK_TRANSPARENT) != '0)
                    begin
                        saw_set = 1'b1;
                        call    = 1'b1;
                        value   = cfg.transparent_index;
                        len     = {4'd0, byte_in[7:1]};
                        ends    = (bytes_dec == '0);
                    end
                    else
                    begin
                        pending_next = {1'b0, byte_in[7:2]} + 7'd1;
                        phase_next   = ((byte_in & srd_pkg::MASK_REPEAT) != '0) ?
                                       PH_REPEAT : PH_LITERAL;
                    end
                end
                PH_REPEAT:
                begin
                    bytes_left_next = bytes_dec;
                    phase_next      = PH_MASK;
                    call            = 1'b1;
                    value           = remapped;
                    len             = {4'd0, pending_reg};
                    ends            = (bytes_dec == '0);
                end
                PH_LITERAL:
                begin
                    bytes_left_next = bytes_dec;
                    pending_next    = pend_dec;
                    call            = 1'b1;
                    value           = remapped;
                    len             = srd_pkg::DimW'(1);
                    ends            = (pend_dec == '0) && (bytes_dec == '0);
                    if (pend_dec == '0)
                    begin
                        phase_next = PH_MASK;
                    end
                end
                default:
                begin
                    phase_next = PH_HDR_LO;
                end
            endcase
        end
    end

    // Clip the run to the pixels left in the row.
    assign col_past = (column_reg >= width);
    assign left     = width - column_reg;
    assign clip     = (len > left);
    assign run_len  = col_past ? '0 : (clip ? left : len);
    assign emit     = call && (run_len != '0);

    always_comb
    begin
        run.pixel_value      = value;
        run.run_length       = run_len;
        run.start_x          = column_reg[srd_pkg::PosW-1:0];
        run.row_index        = row_reg;
        run.row_done         = ends;
        run.frame_done       = ends && last_row;
        run.has_transparency = saw_set;
        run.overflow         = col_past ? (len != '0) : clip;
    end

    always_comb
    begin
        column_next = column_reg;
        row_next    = row_reg;
        saw_next    = saw_set;
        if (call)
        begin
            column_next = column_reg + run_len;
        end
        if (call && ends)
        begin
            column_next = '0;
            if (last_row)
            begin
                row_next = '0;
                saw_next = 1'b0;
            end
            else
            begin
                row_next = row_reg + srd_pkg::PosW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HDR_LO;
            bytes_left_reg <= '0;
            header_reg     <= '0;
            column_reg     <= '0;
            row_reg        <= '0;
            pending_reg    <= '0;
            saw_reg        <= 1'b0;
        end
        else if (restart)
        begin
            phase_reg      <= PH_HDR_LO;
            bytes_left_reg <= '0;
            header_reg     <= '0;
            column_reg     <= '0;
            row_reg        <= '0;
            pending_reg    <= '0;
            saw_reg        <= 1'b0;
        end
        else if (step)
        begin
            column_reg  <= column_next;
            row_reg     <= row_next;
            saw_reg     <= saw_next;
            header_reg  <= header_next;
            if (call && ends)
            begin
                phase_reg      <= PH_HDR_LO;
                bytes_left_reg <= '0;
                pending_reg    <= '0;
            end
            else
            begin
                phase_reg      <= phase_next;
                bytes_left_reg <= bytes_left_next;
                pending_reg    <= pending_next;
            end
        end
    end

endmodule

// ----- rtl/core/sprite_rle_row_decoder.sv -----
// Channel   | Handshake              | Payload
// ----------+------------------------+-------------------------------------------
// stream in | in_valid / in_ready    | stream_byte
// runs out  | out_valid / out_ready  | pixel_value, run_length, start_x,
//           |                        | row_index, row_done, frame_done,
//           |                        | has_transparency, overflow
// config    | cfg_write (no wait)    | cfg_index, cfg_data
//
// One byte is taken every cycle while in_ready is high; the byte register holds
// it and its run is registered in the result register. The rate is set by the
// parse step between the byte register and the result register. Reset (rst_n
// low, asynchronous) restores the register defaults and the start-of-frame parse
// state. When the result register is full and not drained, the byte register
// holds its beat and in_ready falls only once both stages are occupied.
module sprite_rle_row_decoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      stream_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      pixel_value,
    output logic [srd_pkg::DimW-1:0]        run_length,
    output logic [srd_pkg::PosW-1:0]        start_x,
    output logic [srd_pkg::PosW-1:0]        row_index,
    output logic                            row_done,
    output logic                            frame_done,
    output logic                            has_transparency,
    output logic                            overflow,
    input  logic                            cfg_write,
    input  logic [1:0]                      cfg_index,
    input  logic [srd_pkg::DimW-1:0]        cfg_data
);

    srd_pkg::cfg_t cfg_reg;
    logic [7:0]    byte_reg;
    logic          byte_valid_reg;
    logic          out_valid_reg;
    srd_pkg::run_t run_reg;
    srd_pkg::run_t run_comb;
    logic          emit;
    logic          advance;
    logic          step;

    // The result stage can take a new run when it is empty or being drained.
    assign advance  = !out_valid_reg || out_ready;
    assign step     = byte_valid_reg && advance;
    assign in_ready = !byte_valid_reg || advance;

    // Configuration registers. Each write also restarts the frame in the parser.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.compressed_mode   <= 1'b1;
            cfg_reg.transparent_index <= 8'd0;
            cfg_reg.frame_width       <= srd_pkg::DimW'(64);
            cfg_reg.frame_height      <= srd_pkg::DimW'(64);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                srd_pkg::REG_COMPRESSED_MODE:   cfg_reg.compressed_mode   <= cfg_data[0];
                srd_pkg::REG_TRANSPARENT_INDEX: cfg_reg.transparent_index <= cfg_data[7:0];
                srd_pkg::REG_FRAME_WIDTH:       cfg_reg.frame_width       <= cfg_data;
                srd_pkg::REG_FRAME_HEIGHT:      cfg_reg.frame_height      <= cfg_data;
            endcase
        end
    end

    // Input byte register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            byte_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            byte_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= stream_byte;
        end
    end

    srd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .restart (cfg_write),
        .step    (step),
        .byte_in (byte_reg),
        .emit    (emit),
        .run     (run_comb)
    );

    // Result register. Bytes that produce no run simply leave it empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            run_reg <= run_comb;
        end
    end

    assign out_valid        = out_valid_reg;
    assign pixel_value      = run_reg.pixel_value;
    assign run_length       = run_reg.run_length;
    assign start_x          = run_reg.start_x;
    assign row_index        = run_reg.row_index;
    assign row_done         = run_reg.row_done;
    assign frame_done       = run_reg.frame_done;
    assign has_transparency = run_reg.has_transparency;
    assign overflow         = run_reg.overflow;

endmodule
